[rtl/hsl_pkg.sv]
// hsl_pkg: widths, depth and stage types for the halving slice locator.
// No dependencies; used by the interfaces and the top level.

package hsl_pkg;

    localparam int MAX_GROUP = 1024;
    localparam int STEPS     = $clog2(MAX_GROUP);

    localparam int RANK_W   = 10;
    localparam int SIZE_W   = 11;
    localparam int COUNT_W  = 31;
    localparam int EBYTES_W = 13;
    localparam int OFFSET_W = 43;

    // Payload carried down the halving pipeline
    typedef struct packed {
        logic                takes_part;
        logic [RANK_W-1:0]   rank;
        logic [RANK_W-1:0]   rem;
        logic [RANK_W-1:0]   vrank;
        logic [SIZE_W-1:0]   pof2;
        logic [COUNT_W-1:0]  start;
        logic [COUNT_W-1:0]  win;
        logic [EBYTES_W-1:0] element_bytes;
    } stage_t;

endpackage

[rtl/hsl_query_if.sv]
// hsl_query_if: valid/ready channel carrying one slice query.
// Depends on hsl_pkg for field widths.

interface hsl_query_if;
    logic                         valid;
    logic                         ready;
    logic [hsl_pkg::RANK_W-1:0]   rank;
    logic [hsl_pkg::SIZE_W-1:0]   group_size;
    logic [hsl_pkg::COUNT_W-1:0]  element_total;
    logic [hsl_pkg::EBYTES_W-1:0] element_bytes;

    modport source (output valid, rank, group_size, element_total, element_bytes,
                    input ready);
    modport sink   (input valid, rank, group_size, element_total, element_bytes,
                    output ready);
endinterface

[rtl/hsl_slice_if.sv]
// hsl_slice_if: valid/ready channel carrying one owned-slice result.
// Depends on hsl_pkg for field widths.

interface hsl_slice_if;
    logic                         valid;
    logic                         ready;
    logic                         takes_part;
    logic [hsl_pkg::OFFSET_W-1:0] byte_offset;
    logic [hsl_pkg::COUNT_W-1:0]  slice_elements;

    modport source (output valid, takes_part, byte_offset, slice_elements,
                    input ready);
    modport sink   (input valid, takes_part, byte_offset, slice_elements,
                    output ready);
endinterface

[rtl/halving_slice_locator.sv]
// halving_slice_locator: slice owned by a rank after recursive-halving reduce-scatter.
// Depends on hsl_pkg, hsl_query_if and hsl_slice_if.
//
//   channel | dir | payload
//   query   | in  | rank, group_size, element_total, element_bytes
//   slice   | out | takes_part, byte_offset, slice_elements
//
// One transaction per cycle sustained while slice.ready is high; the pipeline is a decode stage,
// one stage per halving step and a multiply-and-output stage.
// rst_n clears only the stage and output valid bits; payload registers are not reset.
// The whole pipeline holds while a result waits on slice.ready; the stall
// propagates straight to query.ready, so nothing is dropped or repeated.

module halving_slice_locator
(
    input  logic               clk,
    input  logic               rst_n,
    hsl_query_if.sink          query,
    hsl_slice_if.source        slice
);

    localparam int STEPS = hsl_pkg::STEPS;

    logic                           advance;
    logic                           stage_valid_reg [0:STEPS];
    hsl_pkg::stage_t                stage_reg       [0:STEPS];
    hsl_pkg::stage_t                decode_next;
    hsl_pkg::stage_t                step_next       [1:STEPS];

    logic                           out_valid_reg;
    logic                           out_part_reg;
    logic [hsl_pkg::OFFSET_W-1:0]   out_offset_reg;
    logic [hsl_pkg::COUNT_W-1:0]    out_count_reg;
    logic [hsl_pkg::OFFSET_W:0]     product;

    assign advance     = !out_valid_reg || slice.ready;
    assign query.ready = advance;

    // Decode: fold the group to a power of two and pick the virtual rank
    always_comb
    begin
        logic [hsl_pkg::SIZE_W-1:0] pof2;
        logic [hsl_pkg::SIZE_W-1:0] rem;
        logic                       bad;
        logic                       folded;
        logic                       part;

        pof2 = '0;
        for (int i = 0; i < hsl_pkg::SIZE_W; i++)
        begin
            if (query.group_size[i])
            begin
                pof2 = hsl_pkg::SIZE_W'(1) << i;
            end
        end
        rem    = query.group_size - pof2;
        bad    = (query.group_size == '0)
              || ({1'b0, query.rank} >= query.group_size)
              || (32'(query.group_size) > 32'(hsl_pkg::MAX_GROUP));
        folded = ({1'b0, query.rank} < {rem[hsl_pkg::SIZE_W-2:0], 1'b0}) && query.rank[0];
        part   = !bad && !folded;

        decode_next.takes_part    = part;
        decode_next.rank          = query.rank;
        decode_next.rem           = rem[hsl_pkg::RANK_W-1:0];
        decode_next.pof2          = part ? pof2 : hsl_pkg::SIZE_W'(1);
        decode_next.vrank         = ({1'b0, query.rank} < {rem[hsl_pkg::SIZE_W-2:0], 1'b0})
                                  ? (query.rank >> 1)
                                  : (query.rank - rem[hsl_pkg::RANK_W-1:0]);
        decode_next.start         = '0;
        // Excluded ranks and single-member groups own nothing
        decode_next.win           = (part && pof2 != hsl_pkg::SIZE_W'(1))
                                  ? query.element_total : '0;
        decode_next.element_bytes = query.element_bytes;
    end

    // One halving step per stage; step k uses partner mask 1<<k
    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        always_comb
        begin
            logic [hsl_pkg::RANK_W-1:0]  mask;
            logic [hsl_pkg::RANK_W-1:0]  vpeer;
            logic [hsl_pkg::SIZE_W-1:0]  peer;
            logic [hsl_pkg::COUNT_W-1:0] half;
            hsl_pkg::stage_t             cur;

            cur   = stage_reg[k];
            mask  = hsl_pkg::RANK_W'(1) << k;
            vpeer = cur.vrank ^ mask;
            peer  = (vpeer < cur.rem) ? {vpeer, 1'b0} : ({1'b0, vpeer} + {1'b0, cur.rem});
            half  = cur.win >> 1;

            step_next[k+1] = cur;
            if (cur.pof2 > {1'b0, mask})
            begin
                if ({1'b0, cur.rank} < peer)
                begin
                    step_next[k+1].win = half;
                end
                else
                begin
                    step_next[k+1].start = cur.start + half;
                    step_next[k+1].win   = cur.win - half;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= STEPS; i++)
            begin
                stage_valid_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            stage_valid_reg[0] <= query.valid;
            for (int i = 1; i <= STEPS; i++)
            begin
                stage_valid_reg[i] <= stage_valid_reg[i-1];
            end
            out_valid_reg <= stage_valid_reg[STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stage_reg[0] <= decode_next;
            for (int i = 1; i <= STEPS; i++)
            begin
                stage_reg[i] <= step_next[i];
            end
            out_part_reg   <= stage_reg[STEPS].takes_part;
            out_offset_reg <= product[hsl_pkg::OFFSET_W-1:0];
            out_count_reg  <= stage_reg[STEPS].win;
        end
    end

    // 31x13 multiply, registered straight into the output stage
    assign product = (hsl_pkg::OFFSET_W+1)'(stage_reg[STEPS].start)
                   * (hsl_pkg::OFFSET_W+1)'(stage_reg[STEPS].element_bytes);

    assign slice.valid          = out_valid_reg;
    assign slice.takes_part     = out_part_reg;
    assign slice.byte_offset    = out_offset_reg;
    assign slice.slice_elements = out_count_reg;

endmodule
